// ===== sv/can_btc_pkg.sv =====
// Shared types, constants and the segment table for the CAN bit timing calculator.
// No dependencies; imported by every other file of the block.
package can_btc_pkg;

    // field widths
    localparam int CLK_W   = 28;
    localparam int RATE_W  = 20;
    localparam int PRESC_W = 11;
    localparam int SEG1_W  = 5;
    localparam int SEG2_W  = 4;
    localparam int SP_W    = 10;
    localparam int WORD_W  = 32;
    localparam int SUM_W   = 5;

    // divider step counter
    localparam int DIV_STEPS = CLK_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // limits and reset values
    localparam logic [CLK_W-1:0]  CLOCK_RESET   = CLK_W'(36000000);
    localparam logic [CLK_W-1:0]  MAX_PRESCALER = CLK_W'(1024);
    localparam logic [RATE_W-1:0] HIGH_RATE     = RATE_W'(1000000);
    localparam logic [SUM_W-1:0]  SUM_HIGH      = SUM_W'(9);   // 10 quanta per bit
    localparam logic [SUM_W-1:0]  SUM_LOW       = SUM_W'(16);  // 17 quanta per bit
    localparam logic [SUM_W-1:0]  SUM_MIN       = SUM_W'(2);   // 3 quanta per bit
    localparam logic [SEG1_W-1:0] SEG1_MAX      = SEG1_W'(16);
    localparam logic [SEG2_W-1:0] SEG2_MAX      = SEG2_W'(8);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PBS  = 4'b0010,
        ST_TRY  = 4'b0100,
        ST_CHK  = 4'b1000
    } state_t;

    // divider request / response
    typedef struct packed {
        logic             start;
        logic [CLK_W-1:0] dividend;
        logic [CLK_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CLK_W-1:0] quotient;
        logic [CLK_W-1:0] remainder;
    } div_rsp_t;

    // segment split for a given seg1+seg2 sum
    typedef struct packed {
        logic [SEG1_W-1:0] seg1;
        logic [SEG2_W-1:0] seg2;
        logic [SP_W-1:0]   sp;
    } seg_t;

    // Seg1 rounded to nearest for a 7/8 sample point, or toward zero when
    // that lands above 900 per mille; sample point truncated.
    function automatic seg_t seg_of(input logic [SUM_W-1:0] sum);
        seg_t r;
        case (sum)
            5'd2:    r = '{SEG1_W'(1),  SEG2_W'(1), SP_W'(666)};
            5'd3:    r = '{SEG1_W'(2),  SEG2_W'(1), SP_W'(750)};
            5'd4:    r = '{SEG1_W'(3),  SEG2_W'(1), SP_W'(800)};
            5'd5:    r = '{SEG1_W'(4),  SEG2_W'(1), SP_W'(833)};
            5'd6:    r = '{SEG1_W'(5),  SEG2_W'(1), SP_W'(857)};
            5'd7:    r = '{SEG1_W'(6),  SEG2_W'(1), SP_W'(875)};
            5'd8:    r = '{SEG1_W'(7),  SEG2_W'(1), SP_W'(888)};
            5'd9:    r = '{SEG1_W'(8),  SEG2_W'(1), SP_W'(900)};
            5'd10:   r = '{SEG1_W'(8),  SEG2_W'(2), SP_W'(818)};
            5'd11:   r = '{SEG1_W'(9),  SEG2_W'(2), SP_W'(833)};
            5'd12:   r = '{SEG1_W'(10), SEG2_W'(2), SP_W'(846)};
            5'd13:   r = '{SEG1_W'(11), SEG2_W'(2), SP_W'(857)};
            5'd14:   r = '{SEG1_W'(12), SEG2_W'(2), SP_W'(866)};
            5'd15:   r = '{SEG1_W'(13), SEG2_W'(2), SP_W'(875)};
            5'd16:   r = '{SEG1_W'(14), SEG2_W'(2), SP_W'(882)};
            default: r = '{SEG1_W'(0),  SEG2_W'(0), SP_W'(0)};
        endcase
        return r;
    endfunction

endpackage

// ===== sv/can_btc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by all divisions.
// Depends on can_btc_pkg (widths, div_req_t, div_rsp_t).
module can_btc_div
    import can_btc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [CLK_W-1:0]  rem_reg, rem_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [CLK_W-1:0]  dsr_reg, dsr_next;
    logic [CLK_W:0]    shifted;
    logic [CLK_W:0]    diff;

    // one step: shift in next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[CLK_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[CLK_W-1:0];
                quo_next = {quo_reg[CLK_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CLK_W-1:0];
                quo_next = {quo_reg[CLK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== sv/can_bit_timing_calculator_core.sv =====
// Top level of the CAN bit timing calculator: sequencer around one shared divider.
// Depends on can_btc_pkg and can_btc_div.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------------
//  request  | bitrate                                   | start && !busy
//  result   | ok, prescaler, seg1_quanta, seg2_quanta,  | done, one cycle
//           | sample_point_permille, timing_word        |
//  config   | clock_hz_wdata                            | clock_hz_we
//
// A zero bitrate answers in the cycle after the request. Otherwise the divider
// runs once for clock/bitrate, once per quanta count tried (up to 15), and,
// if a count divides exactly with the prescaler in range, once to verify the bitrate.
// Reset loads 36 MHz into the clock register; the receiver cannot stall, and for
// a nonzero bitrate busy stays high from request until the cycle the result is shown.
module can_bit_timing_calculator_core
    import can_btc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clock_hz_we,
    input  logic [CLK_W-1:0]   clock_hz_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [RATE_W-1:0]  bitrate,
    output logic               done,
    output logic               ok,
    output logic [PRESC_W-1:0] prescaler,
    output logic [SEG1_W-1:0]  seg1_quanta,
    output logic [SEG2_W-1:0]  seg2_quanta,
    output logic [SP_W-1:0]    sample_point_permille,
    output logic [WORD_W-1:0]  timing_word
);

    state_t             state_reg, state_next;
    logic [CLK_W-1:0]   clock_hz_reg;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CLK_W-1:0]   pbs_reg, pbs_next;
    logic [PRESC_W-1:0] presc_reg, presc_next;

    logic               done_reg;
    logic               ok_reg;
    logic [PRESC_W-1:0] presc_out_reg;
    logic [SEG1_W-1:0]  seg1_reg;
    logic [SEG2_W-1:0]  seg2_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [WORD_W-1:0]  word_reg;

    logic               emit;
    logic               emit_ok;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    seg_t               seg;
    logic [PRESC_W-1:0] presc_m1;
    logic [SEG1_W-1:0]  seg1_m1;
    logic [SEG2_W-1:0]  seg2_m1;
    logic               seg_good;

    can_btc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // segment split follows from the quanta count alone
    assign seg      = seg_of(sum_reg);
    assign seg_good = (seg.seg1 != '0) && (seg.seg1 <= SEG1_MAX) &&
                      (seg.seg2 != '0) && (seg.seg2 <= SEG2_MAX);
    assign presc_m1 = presc_reg - PRESC_W'(1);
    assign seg1_m1  = seg.seg1 - SEG1_W'(1);
    assign seg2_m1  = seg.seg2 - SEG2_W'(1);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        rate_next        = rate_reg;
        sum_next         = sum_reg;
        pbs_next         = pbs_reg;
        presc_next       = presc_reg;
        emit             = 1'b0;
        emit_ok          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = clock_hz_reg;
        div_req.divisor  = CLK_W'(rate_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (bitrate == '0)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        rate_next        = bitrate;
                        sum_next         = (bitrate >= HIGH_RATE) ? SUM_HIGH : SUM_LOW;
                        div_req.start    = 1'b1;
                        div_req.divisor  = CLK_W'(bitrate);
                        state_next       = ST_PBS;
                    end
                end
            end
            ST_PBS:
            begin
                // clock / bitrate ready, try the largest quanta count
                if (div_rsp.done)
                begin
                    pbs_next         = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = CLK_W'(sum_reg) + CLK_W'(1);
                    state_next       = ST_TRY;
                end
            end
            ST_TRY:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        if (div_rsp.quotient == '0 || div_rsp.quotient > MAX_PRESCALER)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // verify: clock / (prescaler * quanta) == bitrate
                            presc_next       = PRESC_W'(div_rsp.quotient);
                            div_req.start    = 1'b1;
                            div_req.dividend = clock_hz_reg;
                            div_req.divisor  = pbs_reg;
                            state_next       = ST_CHK;
                        end
                    end
                    else if (sum_reg <= SUM_MIN)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // one quanta fewer: new divisor equals old sum
                        sum_next         = sum_reg - SUM_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = pbs_reg;
                        div_req.divisor  = CLK_W'(sum_reg);
                    end
                end
            end
            ST_CHK:
            begin
                if (div_rsp.done)
                begin
                    emit       = 1'b1;
                    emit_ok    = (div_rsp.quotient == CLK_W'(rate_reg)) && seg_good;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            clock_hz_reg <= CLOCK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (clock_hz_we)
            begin
                clock_hz_reg <= clock_hz_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        sum_reg   <= sum_next;
        pbs_reg   <= pbs_next;
        presc_reg <= presc_next;
    end

    // result registers, all zero on failure
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ok_reg <= emit_ok;
            if (emit_ok)
            begin
                presc_out_reg <= presc_reg;
                seg1_reg      <= seg.seg1;
                seg2_reg      <= seg.seg2;
                sp_reg        <= seg.sp;
                word_reg      <= {9'b0, seg2_m1[2:0], seg1_m1[3:0], 6'b0, presc_m1[9:0]};
            end
            else
            begin
                presc_out_reg <= '0;
                seg1_reg      <= '0;
                seg2_reg      <= '0;
                sp_reg        <= '0;
                word_reg      <= '0;
            end
        end
    end

    assign busy                  = (state_reg != ST_IDLE);
    assign done                  = done_reg;
    assign ok                    = ok_reg;
    assign prescaler             = presc_out_reg;
    assign seg1_quanta           = seg1_reg;
    assign seg2_quanta           = seg2_reg;
    assign sample_point_permille = sp_reg;
    assign timing_word           = word_reg;

endmodule

// ===== sv/can_btc_checker.sv =====
// Port-level checks for the CAN bit timing calculator, bound to the top level.
// Depends on can_btc_pkg and can_bit_timing_calculator_core.
module can_btc_checker
    import can_btc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [RATE_W-1:0]  bitrate,
    input logic               done,
    input logic               ok,
    input logic [PRESC_W-1:0] prescaler,
    input logic [SEG1_W-1:0]  seg1_quanta,
    input logic [SEG2_W-1:0]  seg2_quanta,
    input logic [SP_W-1:0]    sample_point_permille,
    input logic [WORD_W-1:0]  timing_word
);

    // a failed request shows all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (prescaler == '0 && seg1_quanta == '0 && seg2_quanta == '0 &&
                           sample_point_permille == '0 && timing_word == '0))
        else $error("failed result carries nonzero fields");

    // a good result has a prescaler in range and matching packed word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (prescaler != '0 && prescaler <= PRESC_W'(1024) &&
                          timing_word[9:0] == 10'(prescaler - PRESC_W'(1)) &&
                          timing_word[19:16] == 4'(seg1_quanta - SEG1_W'(1)) &&
                          timing_word[22:20] == 3'(seg2_quanta - SEG2_W'(1))))
        else $error("good result fields inconsistent with timing word");

    // zero bitrate fails on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && bitrate == '0) |=> (done && !ok))
        else $error("zero bitrate not rejected at once");

    // a nonzero request sets busy, with no result yet, once it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && bitrate != '0) |=> (busy && !done))
        else $error("nonzero request did not start the search");

endmodule

bind can_bit_timing_calculator_core can_btc_checker u_can_btc_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .bitrate               (bitrate),
    .done                  (done),
    .ok                    (ok),
    .prescaler             (prescaler),
    .seg1_quanta           (seg1_quanta),
    .seg2_quanta           (seg2_quanta),
    .sample_point_permille (sample_point_permille),
    .timing_word           (timing_word)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for can_bit_timing_calculator_core: directed and random
// bitrate requests over several clock settings, checked against a local timing predictor.
// Depends on can_btc_pkg and the core RTL.

typedef struct packed {
    logic                            ok;
    logic [can_btc_pkg::PRESC_W-1:0] prescaler;
    logic [can_btc_pkg::SEG1_W-1:0]  seg1;
    logic [can_btc_pkg::SEG2_W-1:0]  seg2;
    logic [can_btc_pkg::SP_W-1:0]    sp;
    logic [can_btc_pkg::WORD_W-1:0]  word;
} timing_t;

// Holds the timings still owed by the core, oldest first
class timing_scoreboard;
    timing_t     pending_timings[$];
    int unsigned errors;

    function new();
        errors = 0;
    endfunction

    task report(input string msg);
        $display("t=%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function void note_request(input timing_t want);
        pending_timings.push_back(want);
    endfunction

    task check_result(input timing_t got);
        timing_t want;
        if (pending_timings.size() == 0)
        begin
            report("result with no request outstanding");
            return;
        end
        want = pending_timings.pop_front();
        if (got.ok !== want.ok)
            report($sformatf("ok got %0b expected %0b", got.ok, want.ok));
        if (got.prescaler !== want.prescaler)
            report($sformatf("prescaler got %0d expected %0d", got.prescaler, want.prescaler));
        if (got.seg1 !== want.seg1)
            report($sformatf("seg1 got %0d expected %0d", got.seg1, want.seg1));
        if (got.seg2 !== want.seg2)
            report($sformatf("seg2 got %0d expected %0d", got.seg2, want.seg2));
        if (got.sp !== want.sp)
            report($sformatf("sample point got %0d expected %0d", got.sp, want.sp));
        if (got.word !== want.word)
            report($sformatf("timing word got %h expected %h", got.word, want.word));
    endtask
endclass

module tb_top;
    import can_btc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASES        = 14;
    localparam int unsigned PHASE_ITEMS   = 95;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               clock_hz_we;
    logic [CLK_W-1:0]   clock_hz_wdata;
    logic               start;
    logic               busy;
    logic [RATE_W-1:0]  bitrate;
    logic               done;
    logic               ok;
    logic [PRESC_W-1:0] prescaler;
    logic [SEG1_W-1:0]  seg1_quanta;
    logic [SEG2_W-1:0]  seg2_quanta;
    logic [SP_W-1:0]    sample_point_permille;
    logic [WORD_W-1:0]  timing_word;

    timing_scoreboard   sb;
    logic [CLK_W-1:0]   clock_setting;
    int unsigned        cycle_count = 0;
    timing_t            observed;

    can_bit_timing_calculator_core DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .clock_hz_we           (clock_hz_we),
        .clock_hz_wdata        (clock_hz_wdata),
        .start                 (start),
        .busy                  (busy),
        .bitrate               (bitrate),
        .done                  (done),
        .ok                    (ok),
        .prescaler             (prescaler),
        .seg1_quanta           (seg1_quanta),
        .seg2_quanta           (seg2_quanta),
        .sample_point_permille (sample_point_permille),
        .timing_word           (timing_word)
    );

    always #5 clk = ~clk;

    // Expected timing for one bitrate at a given clock
    function automatic timing_t compute_timing(input logic [CLK_W-1:0] clk_hz,
                                               input logic [RATE_W-1:0] rate);
        timing_t     t;
        int unsigned hz, rq, quanta_top, per_bit, sum, presc, s1, s2, sp;
        t  = '0;
        hz = 32'(clk_hz);
        rq = 32'(rate);
        if (rq == 0)
            return t;
        quanta_top = (rate >= HIGH_RATE) ? 10 : 17;
        per_bit = hz / rq;
        // largest quanta count that divides clocks per bit
        sum = quanta_top - 1;
        while ((per_bit % (sum + 1)) != 0)
        begin
            if (sum <= 2)
                return t;
            sum--;
        end
        presc = per_bit / (sum + 1);
        if (presc < 1 || presc > MAX_PRESCALER)
            return t;
        // round to nearest for 7/8, fall back to truncation above 900 per mille
        s1 = (7 * sum + 3) / 8;
        s2 = sum - s1;
        sp = 1000 * (1 + s1) / (1 + sum);
        if (sp > 900)
        begin
            s1 = (7 * sum - 1) / 8;
            s2 = sum - s1;
            sp = 1000 * (1 + s1) / (1 + sum);
        end
        if (rq != hz / (presc * (1 + s1 + s2)) || s1 < 1 || s1 > SEG1_MAX ||
            s2 < 1 || s2 > SEG2_MAX)
            return t;
        t.ok        = 1'b1;
        t.prescaler = presc[PRESC_W-1:0];
        t.seg1      = s1[SEG1_W-1:0];
        t.seg2      = s2[SEG2_W-1:0];
        t.sp        = sp[SP_W-1:0];
        t.word      = ((presc - 1) & 32'h3FF) | (((s1 - 1) & 32'hF) << 16) |
                      (((s2 - 1) & 32'h7) << 20);
        return t;
    endfunction

    // Random bitrate, mostly aimed at exact divisors of the clock
    function automatic logic [RATE_W-1:0] pick_bitrate(input logic [CLK_W-1:0] clk_hz);
        int unsigned r, p, q, rate;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            q = $urandom_range(3, 17);
            p = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 1100);
            rate = clk_hz / (p * q);
            if (rate == 0 || rate > 20'hFFFFF)
                rate = $urandom_range(1, 20'hFFFFF);
        end
        else if (r < 65)
        begin
            case ($urandom_range(0, 7))
                0:       rate = 10000;
                1:       rate = 20000;
                2:       rate = 50000;
                3:       rate = 83333;
                4:       rate = 125000;
                5:       rate = 250000;
                6:       rate = 500000;
                default: rate = 1000000;
            endcase
        end
        else if (r < 72)
            rate = $urandom_range(999000, 20'hFFFFF);
        else if (r < 80)
            rate = $urandom_range(0, 1000);
        else
            rate = $urandom & 20'hFFFFF;
        return rate[RATE_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] directed_rate(input int unsigned idx);
        case (idx)
            0:       return 20'd0;
            1:       return 20'd1;
            2:       return 20'hFFFFF;
            3:       return 20'd1000000;
            4:       return 20'd999999;
            5:       return 20'd631578;   // three quanta, sample point pulled back
            6:       return 20'd473684;   // four quanta, sample point pulled back
            7:       return 20'd972972;   // no exact divisor
            8:       return 20'd500000;
            9:       return 20'd250000;
            10:      return 20'd125000;
            11:      return 20'd100000;
            12:      return 20'd50000;
            13:      return 20'd10000;
            14:      return 20'd2000;     // prescaler too large
            15:      return 20'd800000;
            16:      return 20'h55555;
            default: return 20'hAAAAA;
        endcase
    endfunction

    function automatic logic [CLK_W-1:0] phase_clock(input int unsigned phase);
        case (phase)
            0:       return CLK_W'(80000000);
            1:       return CLK_W'(0);
            2:       return CLK_W'(8000000);
            3:       return CLK_W'(200000000);
            4:       return CLK_W'(1);
            5:       return {CLK_W{1'b1}};
            6:       return CLK_W'(48000000);
            7:       return CLK_W'(16000000);
            8:       return CLK_W'(64000000);
            9:       return CLK_W'(24000000);
            10:      return CLK_W'(40000000);
            13:      return CLOCK_RESET;
            default: return CLK_W'($urandom_range(1, 200000000));
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hold a request on the port until the core takes it
    task drive_request(input logic [RATE_W-1:0] rate);
        @(negedge clk);
        start   <= 1'b1;
        bitrate <= rate;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(compute_timing(clock_setting, rate));
    endtask

    task idle_cycles(input int unsigned n);
        @(negedge clk);
        start   <= 1'b0;
        bitrate <= RATE_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Stop sending and let every outstanding result come back
    task wait_drained();
        @(negedge clk);
        start   <= 1'b0;
        bitrate <= RATE_W'($urandom);
        while (sb.pending_timings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the core idle
    task write_clock(input logic [CLK_W-1:0] value);
        @(negedge clk);
        clock_hz_we    <= 1'b1;
        clock_hz_wdata <= value;
        @(negedge clk);
        clock_hz_we    <= 1'b0;
        clock_hz_wdata <= '0;
        clock_setting = value;
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            observed = '{ok, prescaler, seg1_quanta, seg2_quanta,
                         sample_point_permille, timing_word};
            sb.check_result(observed);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned i;
        int unsigned phase;
        int unsigned gap;
        bit          no_gaps;

        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        bitrate        = '0;
        clock_hz_we    = 1'b0;
        clock_hz_wdata = '0;
        clock_setting  = CLOCK_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset clock
        for (i = 0; i < 18; i++)
        begin
            if (i % 5 == 4)
                idle_cycles($urandom_range(1, 30));
            drive_request(directed_rate(i));
        end
        wait_drained();

        // random requests, one clock setting per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_clock(phase_clock(phase));
            no_gaps = (phase == 2) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                gap = no_gaps ? 0 : pick_gap();
                if (gap != 0)
                    idle_cycles(gap);
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                drive_request(pick_bitrate(clock_setting));
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending_timings.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
